// File: sv/tocq_pkg.sv
// tocq_pkg: shared types and codes for the timestamp ordered channel queues
// used by tocq_ctrl, tocq_datapath and timestamp_ordered_channel_queues
// no dependencies
package tocq_pkg;

   // field widths of one beat
   localparam int unsigned CHAN_W   = 2;
   localparam int unsigned TS_W     = 64;
   localparam int unsigned PL_W     = 32;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned TDATA_W  = 104;

   // action codes on req_tuser
   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   // status codes on rsp_tuser
   localparam logic [STATUS_W-1:0] ST_PUSHED    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_OVERWRITE = 2'd1;
   localparam logic [STATUS_W-1:0] ST_POPPED    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd3;

   // channel select source for the position and memory address path
   localparam logic [1:0] SEL_ITEM = 2'd0;
   localparam logic [1:0] SEL_SCAN = 2'd1;
   localparam logic [1:0] SEL_BEST = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       capture;
      logic       scan_issue;
      logic       do_push;
      logic       do_pop;
      logic [1:0] sel_src;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic item_pop;
      logic scan_last;
      logic rsp_free;
   } ctl_sts_type;

endpackage

// File: sv/tocq_ctrl.sv
// tocq_ctrl: sequencer for push and pop beats
// depends on tocq_pkg for the command and status structs
module tocq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  tocq_pkg::ctl_sts_type sts,
   output tocq_pkg::ctl_cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_PUSH  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_POP   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_tready = (state_ff == S_IDLE);

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cmd.capture    = 1'b0;
      cmd.scan_issue = 1'b0;
      cmd.do_push    = 1'b0;
      cmd.do_pop     = 1'b0;
      cmd.sel_src    = tocq_pkg::SEL_ITEM;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_PUSH;
            end
         end
         S_PUSH: begin
            // item registers hold the beat now; pop goes to the head scan
            if (sts.item_pop) begin
               state_in = S_SCAN;
            end else if (sts.rsp_free) begin
               cmd.do_push = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.sel_src    = tocq_pkg::SEL_SCAN;
            cmd.scan_issue = 1'b1;
            if (sts.scan_last) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_POP;
         end
         S_POP: begin
            cmd.sel_src = tocq_pkg::SEL_BEST;
            if (sts.rsp_free) begin
               cmd.do_pop = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: sv/tocq_datapath.sv
// tocq_datapath: ring positions, message memory, head compare and result register
// depends on tocq_pkg for widths, codes and the command and status structs
module tocq_datapath #(
   parameter int unsigned CHANNELS    = 4,
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tocq_pkg::ctl_cmd_type          cmd,
   output tocq_pkg::ctl_sts_type          sts,
   input  logic [tocq_pkg::TDATA_W-1:0]   req_tdata,
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tocq_pkg::TDATA_W-1:0]   rsp_tdata,
   output logic [tocq_pkg::STATUS_W-1:0]  rsp_tuser
);

   localparam int unsigned CH_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int unsigned CIW       = (CH_W > 2) ? CH_W : 2;
   localparam int unsigned POS_W     = $clog2(2 * QUEUE_DEPTH);
   localparam int unsigned SLOT_W    = $clog2(QUEUE_DEPTH);
   localparam int unsigned MEM_DEPTH = CHANNELS * QUEUE_DEPTH;
   localparam int unsigned AW        = $clog2(MEM_DEPTH);
   localparam int unsigned TS_W      = tocq_pkg::TS_W;
   localparam int unsigned PL_W      = tocq_pkg::PL_W;
   localparam int unsigned CHAN_W    = tocq_pkg::CHAN_W;
   localparam int unsigned WORD_W    = TS_W + PL_W;
   localparam int unsigned PAD_W     = tocq_pkg::TDATA_W - CHAN_W - TS_W - PL_W;

   localparam logic [POS_W-1:0]  POS_LAST   = POS_W'(2 * QUEUE_DEPTH - 1);
   localparam logic [POS_W-1:0]  DEPTH_P    = POS_W'(QUEUE_DEPTH);
   localparam logic [POS_W:0]    POS_MOD    = (POS_W + 1)'(2 * QUEUE_DEPTH);
   localparam logic [POS_W:0]    DEPTH_F    = (POS_W + 1)'(QUEUE_DEPTH);
   localparam logic [AW-1:0]     DEPTH_A    = AW'(QUEUE_DEPTH);
   localparam logic [4:0]        CHANNELS_V = 5'(CHANNELS);
   localparam logic [CH_W-1:0]   SCAN_LAST  = CH_W'(CHANNELS - 1);

   // ring positions, one pair per channel
   logic [POS_W-1:0] wr_pos_ff [CHANNELS];
   logic [POS_W-1:0] wr_pos_in [CHANNELS];
   logic [POS_W-1:0] rd_pos_ff [CHANNELS];
   logic [POS_W-1:0] rd_pos_in [CHANNELS];

   // captured beat
   logic              act_ff;
   logic [CHAN_W-1:0] chan_ff;
   logic [TS_W-1:0]   ts_ff;
   logic [PL_W-1:0]   pl_ff;

   // head scan
   logic [CH_W-1:0]   scan_cnt_ff;
   logic              cand_valid_ff;
   logic [CH_W-1:0]   cand_ch_ff;
   logic              found_ff;
   logic [CH_W-1:0]   best_ch_ff;
   logic [TS_W-1:0]   best_ts_ff;
   logic [PL_W-1:0]   best_pl_ff;

   // message memory
   logic [WORD_W-1:0] mem [MEM_DEPTH];
   logic [WORD_W-1:0] mem_q_ff;

   // result register
   logic                          rsp_valid_ff;
   logic [tocq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [CHAN_W-1:0]             rsp_chan_ff;
   logic [TS_W-1:0]               rsp_ts_ff;
   logic [PL_W-1:0]               rsp_pl_ff;

   logic [CIW-1:0]    chan_wide;
   logic [CIW-1:0]    best_wide;
   logic              chan_ok;
   logic [CH_W-1:0]   sel_ch;
   logic [POS_W-1:0]  sel_wr;
   logic [POS_W-1:0]  sel_rd;
   logic [POS_W:0]    fill;
   logic              sel_full;
   logic              sel_empty;
   logic [POS_W-1:0]  slot_pos;
   logic [SLOT_W-1:0] slot;
   logic [AW-1:0]     addr;
   logic              mem_we;
   logic              mem_re;
   logic              take_best;

   assign chan_wide = CIW'(chan_ff);
   assign best_wide = CIW'(best_ch_ff);
   assign chan_ok   = {3'b000, chan_ff} < CHANNELS_V;

   // channel select for positions and address
   always_comb begin
      case (cmd.sel_src)
         tocq_pkg::SEL_SCAN: sel_ch = scan_cnt_ff;
         tocq_pkg::SEL_BEST: sel_ch = best_ch_ff;
         default:            sel_ch = chan_wide[CH_W-1:0];
      endcase
   end

   assign sel_wr = wr_pos_ff[sel_ch];
   assign sel_rd = rd_pos_ff[sel_ch];

   // fill level modulo twice the depth
   assign fill      = (sel_wr >= sel_rd) ? ({1'b0, sel_wr} - {1'b0, sel_rd})
                                         : ({1'b0, sel_wr} + POS_MOD - {1'b0, sel_rd});
   assign sel_full  = fill >= DEPTH_F;
   assign sel_empty = (sel_wr == sel_rd);

   // slot address: write position on push, read position on scan
   assign slot_pos = cmd.scan_issue ? sel_rd : sel_wr;
   assign slot     = (slot_pos >= DEPTH_P) ? SLOT_W'(slot_pos - DEPTH_P) : SLOT_W'(slot_pos);
   assign addr     = AW'(AW'(sel_ch) * DEPTH_A) + AW'(slot);

   assign mem_we = cmd.do_push && chan_ok;
   assign mem_re = cmd.scan_issue && !sel_empty;

   // memory, one write and one registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[addr] <= {pl_ff, ts_ff};
      end
      if (mem_re) begin
         mem_q_ff <= mem[addr];
      end
   end

   // position updates
   always_comb begin
      wr_pos_in = wr_pos_ff;
      rd_pos_in = rd_pos_ff;
      if (mem_we) begin
         wr_pos_in[sel_ch] = (sel_wr == POS_LAST) ? '0 : sel_wr + 1'b1;
         if (sel_full) begin
            rd_pos_in[sel_ch] = (sel_rd == POS_LAST) ? '0 : sel_rd + 1'b1;
         end
      end else if (cmd.do_pop && found_ff) begin
         rd_pos_in[sel_ch] = (sel_rd == POS_LAST) ? '0 : sel_rd + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            wr_pos_ff[i] <= '0;
            rd_pos_ff[i] <= '0;
         end
      end else begin
         wr_pos_ff <= wr_pos_in;
         rd_pos_ff <= rd_pos_in;
      end
   end

   // beat capture
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= req_tuser;
         chan_ff <= req_tdata[CHAN_W-1:0];
         ts_ff   <= req_tdata[CHAN_W +: TS_W];
         pl_ff   <= req_tdata[CHAN_W+TS_W +: PL_W];
      end
   end

   // scan counter and candidate tag, one channel head per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_cnt_ff   <= '0;
         cand_valid_ff <= 1'b0;
      end else begin
         cand_valid_ff <= mem_re;
         if (cmd.capture) begin
            scan_cnt_ff <= '0;
         end else if (cmd.scan_issue) begin
            scan_cnt_ff <= scan_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_issue) begin
         cand_ch_ff <= scan_cnt_ff;
      end
   end

   // running minimum over the heads, lowest channel kept on ties
   assign take_best = cand_valid_ff && (!found_ff || (mem_q_ff[TS_W-1:0] < best_ts_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.capture) begin
         found_ff <= 1'b0;
      end else if (take_best) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (take_best) begin
         best_ch_ff <= cand_ch_ff;
         best_ts_ff <= mem_q_ff[TS_W-1:0];
         best_pl_ff <= mem_q_ff[TS_W +: PL_W];
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.do_push || cmd.do_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_push) begin
         rsp_status_ff <= (chan_ok && sel_full) ? tocq_pkg::ST_OVERWRITE : tocq_pkg::ST_PUSHED;
         rsp_chan_ff   <= chan_ff;
         rsp_ts_ff     <= '0;
         rsp_pl_ff     <= '0;
      end else if (cmd.do_pop) begin
         if (found_ff) begin
            rsp_status_ff <= tocq_pkg::ST_POPPED;
            rsp_chan_ff   <= best_wide[CHAN_W-1:0];
            rsp_ts_ff     <= best_ts_ff;
            rsp_pl_ff     <= best_pl_ff;
         end else begin
            rsp_status_ff <= tocq_pkg::ST_EMPTY;
            rsp_chan_ff   <= '0;
            rsp_ts_ff     <= '0;
            rsp_pl_ff     <= '0;
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_pl_ff, rsp_ts_ff, rsp_chan_ff};

   // status to the sequencer
   assign sts.item_pop  = (act_ff == tocq_pkg::ACT_POP);
   assign sts.scan_last = (scan_cnt_ff == SCAN_LAST);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_tready;

endmodule

// File: sv/timestamp_ordered_channel_queues.sv
// timestamp_ordered_channel_queues: top level of the per-channel timestamp queues
// depends on tocq_pkg, tocq_ctrl and tocq_datapath
//
//   channel   signals                          beat contents (lowest bit first)
//   req       req_tvalid/tready/tdata/tuser    tuser: action; tdata: channel, timestamp, payload
//   rsp       rsp_tvalid/tready/tdata/tuser    tuser: status; tdata: out_channel,
//                                              out_timestamp, out_payload
//
// a push goes through capture, then the memory write together with the result load
// a pop goes through capture, action decode, one memory read per channel head through the
// single read port, the last compare, then the result load
// reset clears the ring positions, so every queue starts empty; message memory is not cleared
// a stalled result holds in the output register; the next beat is accepted meanwhile and
// waits for the register to free before its result is loaded
module timestamp_ordered_channel_queues #(
   parameter int unsigned CHANNELS    = 4,
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // channel[1:0], timestamp[65:2], payload[97:66], zero pad[103:98]
   input  logic [tocq_pkg::TDATA_W-1:0]  req_tdata,
   // action
   input  logic                          req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // out_channel[1:0], out_timestamp[65:2], out_payload[97:66], zero pad[103:98]
   output logic [tocq_pkg::TDATA_W-1:0]  rsp_tdata,
   // status
   output logic [tocq_pkg::STATUS_W-1:0] rsp_tuser
);

   tocq_pkg::ctl_cmd_type cmd;
   tocq_pkg::ctl_sts_type sts;

   // sequencer
   tocq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // queues, compare and result register
   tocq_datapath #(
      .CHANNELS    (CHANNELS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // one beat at a time: no accept in the cycle after an accept
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("accept directly after accept");

   // a result is never loaded over one still waiting
   assert property (@(posedge clock) disable iff (reset)
      (cmd.do_push || cmd.do_pop) |-> (!rsp_tvalid || rsp_tready))
      else $error("result register overwritten while stalled");

   // an empty pop carries all-zero data
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && (rsp_tuser == tocq_pkg::ST_EMPTY)) |-> (rsp_tdata == '0))
      else $error("empty result with nonzero data");

   // push results carry zero timestamp and payload
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && ((rsp_tuser == tocq_pkg::ST_PUSHED) ||
                      (rsp_tuser == tocq_pkg::ST_OVERWRITE)))
      |-> (rsp_tdata[tocq_pkg::TDATA_W-1:tocq_pkg::CHAN_W] == '0))
      else $error("push result with nonzero message fields");

endmodule
